### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the ray/sphere intersection block.
// Expects clk_i and rst_ni (active low) in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition never holds.
`define ASSERT_NEVER(lbl, expr, msg) \
  `ASSERT_AT(lbl, !(expr), msg)

`endif

### hw/rtl/rsi_pkg.sv
// Package of the ray/sphere intersection block: widths, codes and word types.
// No dependencies; used by every module of the block.
`default_nettype none

package rsi_pkg;

  localparam int COORD_W         = 24;
  localparam int DIR_W           = 16;
  localparam int RADIUS_W        = 23;
  localparam int COORD_FRAC_BITS = 8;
  localparam int DIR_FRAC_BITS   = 14;

  localparam int DELTA_W = COORD_W + 1;
  localparam int DOTP_W  = DELTA_W + DIR_W;
  localparam int DOT_W   = DOTP_W + 2;
  localparam int H_W     = DOT_W - DIR_FRAC_BITS;
  localparam int SQ_W    = 2 * DELTA_W;
  localparam int SQS_W   = SQ_W + 2;
  localparam int RR_W    = 2 * (RADIUS_W + 1);
  localparam int C_W     = SQS_W + 1;
  localparam int HH_W    = 2 * H_W;
  localparam int DISC_W  = HH_W + 1;
  localparam int RAD_W   = DISC_W - 1;
  localparam int ROOT_W  = RAD_W / 2;
  localparam int REM_W   = RAD_W + 1;
  localparam int T_W     = H_W + 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    HIT_MISS    = 2'd0,
    HIT_OUTSIDE = 2'd1,
    HIT_INSIDE  = 2'd2
  } hit_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_CENTER_Z = 2'd2,
    CFG_RADIUS   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [DIR_W-1:0]   dir_x;
    logic signed [DIR_W-1:0]   dir_y;
    logic signed [DIR_W-1:0]   dir_z;
  } ray_t;

  typedef struct packed {
    hit_kind_e                 hit_kind;
    logic signed [COORD_W-1:0] distance;
  } hit_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic [RADIUS_W-1:0]       radius;
  } sphere_t;

  typedef struct packed {
    logic signed [H_W-1:0]    h;
    logic signed [DISC_W-1:0] disc;
  } disc_t;

endpackage

`default_nettype wire

### hw/rtl/rsi_front.sv
// Front pipeline: takes rays, forms the half dot product h and the discriminant.
// Depends on rsi_pkg; feeds rsi_fifo.
`default_nettype none

module rsi_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rsi_pkg::ray_t   in_word_i,
  input  rsi_pkg::sphere_t sphere_i,
  input  logic            full_i,
  output logic            push_o,
  output rsi_pkg::disc_t  push_word_o
);
  import rsi_pkg::*;

  localparam logic signed [DOT_W-1:0] DOT_RND = DOT_W'(2 ** (DIR_FRAC_BITS - 1));

  logic adv;
  logic v1_q, v2_q, v3_q, v4_q;

  logic signed [DELTA_W-1:0] dx_q, dy_q, dz_q;
  logic signed [DIR_W-1:0]   ux_q, uy_q, uz_q;
  logic [RADIUS_W-1:0]       r_q;
  logic signed [RADIUS_W:0]  rs;

  logic signed [DOTP_W-1:0]  px_q, py_q, pz_q;
  logic signed [SQ_W-1:0]    sx_q, sy_q, sz_q;
  logic signed [RR_W-1:0]    rr_q;

  logic signed [DOT_W-1:0]   dot_s;
  logic signed [SQS_W-1:0]   sqs_s;
  logic signed [C_W-1:0]     c_s;

  logic signed [H_W-1:0]     h3_q, h4_q;
  logic signed [C_W-1:0]     c3_q, c4_q;
  logic signed [HH_W-1:0]    hh_q;

  assign adv        = !v4_q || !full_i;
  assign in_ready_o = adv;
  assign push_o     = v4_q && !full_i;

  assign rs    = $signed({1'b0, r_q});
  assign dot_s = px_q + py_q + pz_q + DOT_RND;
  assign sqs_s = sx_q + sy_q + sz_q;
  assign c_s   = sqs_s - rr_q;

  assign push_word_o.h    = h4_q;
  assign push_word_o.disc = hh_q - c4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_q <= in_word_i.origin_x - sphere_i.center_x;
      dy_q <= in_word_i.origin_y - sphere_i.center_y;
      dz_q <= in_word_i.origin_z - sphere_i.center_z;
      ux_q <= in_word_i.dir_x;
      uy_q <= in_word_i.dir_y;
      uz_q <= in_word_i.dir_z;
      r_q  <= sphere_i.radius;

      px_q <= dx_q * ux_q;
      py_q <= dy_q * uy_q;
      pz_q <= dz_q * uz_q;
      sx_q <= dx_q * dx_q;
      sy_q <= dy_q * dy_q;
      sz_q <= dz_q * dz_q;
      rr_q <= rs * rs;

      h3_q <= dot_s[DOT_W-1:DIR_FRAC_BITS];
      c3_q <= c_s;

      hh_q <= h3_q * h3_q;
      h4_q <= h3_q;
      c4_q <= c3_q;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rsi_fifo.sv
// Short queue of discriminant words between the front and back pipelines.
// Depends on rsi_pkg and assert_macros.svh.
`default_nettype none

module rsi_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rsi_pkg::disc_t push_word_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output rsi_pkg::disc_t pop_word_o
);
  import rsi_pkg::*;

  `include "assert_macros.svh"

  disc_t              mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [FIFO_AW:0]   cnt_q;

  assign full_o     = cnt_q == (FIFO_AW + 1)'(FIFO_DEPTH);
  assign empty_o    = cnt_q == '0;
  assign pop_word_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `ASSERT_NEVER(a_fifo_overflow, push_i && full_o, "word pushed into full queue")
  `ASSERT_NEVER(a_fifo_underflow, pop_i && empty_o, "word popped from empty queue")

endmodule

`default_nettype wire

### hw/rtl/rsi_back.sv
// Back pipeline: one square root bit per stage, root choice, saturation, output register.
// Depends on rsi_pkg and assert_macros.svh; fed by rsi_fifo.
`default_nettype none

module rsi_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  output logic           pop_o,
  input  rsi_pkg::disc_t pop_word_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rsi_pkg::hit_t  out_word_o
);
  import rsi_pkg::*;

  `include "assert_macros.svh"

  localparam logic signed [T_W-1:0] DIST_MAX = T_W'(2 ** (COORD_W - 1) - 1);
  localparam logic signed [T_W-1:0] DIST_MIN = -DIST_MAX - T_W'(1);
  localparam logic signed [COORD_W-1:0] MISS_DIST = COORD_W'(-(2 ** COORD_FRAC_BITS));

  function automatic logic signed [COORD_W-1:0] sat_dist(input logic signed [T_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > DIST_MAX) begin
      r = DIST_MAX[COORD_W-1:0];
    end else if (v < DIST_MIN) begin
      r = DIST_MIN[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

  logic adv;
  logic [ROOT_W:0]        vld_q;
  logic [ROOT_W:0]        neg_q;
  logic signed [H_W-1:0]  h_q    [ROOT_W+1];
  logic [REM_W-1:0]       rem_q  [ROOT_W+1];
  logic [ROOT_W-1:0]      root_q [ROOT_W+1];
  logic [REM_W-1:0]       rem_n  [ROOT_W+1];
  logic [ROOT_W-1:0]      root_n [ROOT_W+1];

  logic signed [T_W-1:0]  hx, sx, t1, t2;
  hit_t                   res;
  logic                   out_vld_q;
  hit_t                   out_word_q;

  assign adv   = !out_vld_q || out_ready_i;
  assign pop_o = adv && !empty_i;

  assign rem_n[0]  = pop_word_i.disc[DISC_W-1] ? '0 : {1'b0, pop_word_i.disc[RAD_W-1:0]};
  assign root_n[0] = '0;

  for (genvar k = 1; k <= ROOT_W; k++) begin : g_sqrt
    localparam int B = ROOT_W - k;
    logic [REM_W-1:0] term;
    logic             ge;
    assign term      = (REM_W'(root_q[k-1]) << (B + 1)) + (REM_W'(1) << (2 * B));
    assign ge        = rem_q[k-1] >= term;
    assign rem_n[k]  = ge ? rem_q[k-1] - term : rem_q[k-1];
    assign root_n[k] = ge ? root_q[k-1] | (ROOT_W'(1) << B) : root_q[k-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[ROOT_W-1:0], !empty_i};
      out_vld_q <= vld_q[ROOT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      neg_q     <= {neg_q[ROOT_W-1:0], pop_word_i.disc[DISC_W-1]};
      h_q[0]    <= pop_word_i.h;
      rem_q[0]  <= rem_n[0];
      root_q[0] <= root_n[0];
      for (int k = 1; k <= ROOT_W; k++) begin
        h_q[k]    <= h_q[k-1];
        rem_q[k]  <= rem_n[k];
        root_q[k] <= root_n[k];
      end
      if (vld_q[ROOT_W]) begin
        out_word_q <= res;
      end
    end
  end

  assign hx = T_W'(h_q[ROOT_W]);
  assign sx = $signed(T_W'(root_q[ROOT_W]));
  assign t1 = -hx - sx;
  assign t2 = sx - hx;

  always_comb begin
    if (neg_q[ROOT_W]) begin
      res.hit_kind = HIT_MISS;
      res.distance = MISS_DIST;
    end else if (t1 < 0 && t2 > 0) begin
      res.hit_kind = HIT_INSIDE;
      res.distance = sat_dist(t2);
    end else begin
      res.hit_kind = (t1 < 0) ? HIT_MISS : HIT_OUTSIDE;
      res.distance = sat_dist(t1);
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_word_q;

  `ASSERT_AT(a_last_stage_reaches_out, vld_q[ROOT_W] && adv |=> out_vld_q, "word lost at output")
  `ASSERT_AT(a_inside_ahead, out_vld_q && out_word_q.hit_kind == HIT_INSIDE |-> out_word_q.distance > 0, "inside hit with distance not ahead")

endmodule

`default_nettype wire

### hw/rtl/ray_sphere_intersect_top.sv
// Top level of the ray/sphere intersection block: sphere registers and the pipeline.
// Depends on rsi_pkg, rsi_front, rsi_fifo and rsi_back.
//
//   port group      dir   width  handshake
//   in_*  (ray)     in    120    in_valid_i / in_ready_o
//   out_* (hit)     out   26     out_valid_o / out_ready_i
//   cfg_* (sphere)  in    24     cfg_we_i, no wait
//
// One ray per cycle while the output is not stalled; a ray passes 4 front stages, the queue and
// 31 back stages (an entry stage, one square root bit per stage for 29 bits,
// then the output register).
// Reset clears valid flags, queue pointers and the sphere registers; no clearing pass.
// A stalled output freezes the back stages; the 4-word queue then fills before the
// front stalls and in_ready_o drops.
`default_nettype none

module ray_sphere_intersect_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  rsi_pkg::ray_t                      in_word_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output rsi_pkg::hit_t                      out_word_o,
  input  logic                               cfg_we_i,
  input  logic [rsi_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rsi_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import rsi_pkg::*;

  sphere_t sphere_q;
  logic    push, full, pop, empty;
  disc_t   push_word, pop_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sphere_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CENTER_X: sphere_q.center_x <= cfg_wdata_i;
        CFG_CENTER_Y: sphere_q.center_y <= cfg_wdata_i;
        CFG_CENTER_Z: sphere_q.center_z <= cfg_wdata_i;
        CFG_RADIUS:   sphere_q.radius   <= cfg_wdata_i[RADIUS_W-1:0];
      endcase
    end
  end

  rsi_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .sphere_i    (sphere_q),
    .full_i      (full),
    .push_o      (push),
    .push_word_o (push_word)
  );

  rsi_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_word_i (push_word),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_word_o  (pop_word)
  );

  rsi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pop_o       (pop),
    .pop_word_i  (pop_word),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire
